// ===== rtl/wsts_pkg.sv =====
// Shared constants, payload types, memory port types and sequencer states for the sum-tree sampler.
`timescale 1ns / 1ps

package wsts_pkg;

    localparam int LEAVES      = 1024;
    localparam int LEAF_BITS   = $clog2(LEAVES);     // leaf / node address width
    localparam int IDX_BITS    = LEAF_BITS + 1;      // holds LEAVES itself
    localparam int WEIGHT_BITS = 24;
    localparam int SUM_BITS    = 34;
    localparam int LVL_BITS    = $clog2(LEAF_BITS + 1);

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam logic CFG_IDX_NUM_ITEMS = 1'b0;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_REBUILD = 2'd1;
    localparam logic [1:0] CMD_SAMPLE  = 2'd2;
    localparam logic [1:0] CMD_REMOVE  = 2'd3;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [LEAF_BITS-1:0]   item_index;
        logic [WEIGHT_BITS-1:0] weight;
        logic [SUM_BITS-1:0]    query;
    } wsts_in_t;

    typedef struct packed {
        logic [IDX_BITS-1:0] picked_index;
        logic [SUM_BITS-1:0] remaining_sum;
    } wsts_out_t;

    typedef struct packed {
        logic                 en;
        logic [LEAF_BITS-1:0] addr;
    } wsts_rd_t;

    typedef struct packed {
        logic                   en;
        logic [LEAF_BITS-1:0]   addr;
        logic [WEIGHT_BITS-1:0] data;
    } wsts_leaf_wr_t;

    typedef struct packed {
        logic                 en;
        logic [LEAF_BITS-1:0] addr;
        logic [SUM_BITS-1:0]  data;
    } wsts_node_wr_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_REBUILD  = 9'b000000010,
        ST_DESC_RD  = 9'b000000100,
        ST_DESC_CMP = 9'b000001000,
        ST_LEAF_RD  = 9'b000010000,
        ST_LEAF_W   = 9'b000100000,
        ST_UP_CHK   = 9'b001000000,
        ST_UP_WR    = 9'b010000000,
        ST_DONE     = 9'b100000000
    } wsts_state_t;

endpackage

// ===== rtl/weighted_sum_tree_sampler_core.sv =====
// Top level of the sum-tree sampler: APB register, command sequencer, shared subtractor.
`timescale 1ns / 1ps

// Weighted sum-tree sampler over 1024 leaves.
// Input channel (in_valid/in_ready/in_data) carries one command transaction:
//   load writes one leaf weight, rebuild recomputes all left-subtree sums and
//   the remaining total, sample walks root to leaf, sample-with-removal also
//   subtracts the picked weight from its left-side ancestors and the total.
// Output channel (out_valid/out_ready/out_data) returns one transaction per
//   command: picked index (limited to num_items) and remaining sum.
// num_items is set over the APB port (byte address 0); the user must write it only
//   while the block is idle, and the block itself does not enforce this.
// One command is in flight at a time. A sample reads and compares one node per
//   level, root to leaf; a removal then reads the leaf and climbs back, writing
//   the parent of each left child. Rebuild streams one leaf per cycle.
// After reset both memories are cleared by a sweep over all 1024 entries; in_ready
//   stays low until it ends, APB writes are taken throughout.
// A stalled receiver holds the result in the output register; the next command
//   is still accepted and runs, then waits for the output register to free up.

module weighted_sum_tree_sampler_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  wsts_pkg::wsts_in_t                    in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output wsts_pkg::wsts_out_t                   out_data,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [wsts_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [wsts_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [wsts_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                  pready
);

    localparam int LB = wsts_pkg::LEAF_BITS;
    localparam int IB = wsts_pkg::IDX_BITS;
    localparam int SB = wsts_pkg::SUM_BITS;

    wsts_pkg::wsts_state_t state_reg, state_next;

    logic [IB-1:0]                    num_items_reg;
    logic [IB-1:0]                    node_reg, node_next;   // heap index, also walks back up
    logic [SB-1:0]                    query_reg, query_next;
    logic                             remove_reg, remove_next;
    logic [wsts_pkg::WEIGHT_BITS-1:0] w_reg, w_next;
    logic [SB-1:0]                    total_reg, total_next;
    logic [IB-1:0]                    picked_reg, picked_next;
    logic                             out_valid_reg;
    wsts_pkg::wsts_out_t              out_data_reg;

    logic                             in_acc;
    logic                             out_load;
    logic                             cfg_wr;
    logic                             rb_start;
    logic                             clear_busy;

    wsts_pkg::wsts_leaf_wr_t          leaf_wr;
    wsts_pkg::wsts_rd_t               leaf_rd, rb_leaf_rd;
    wsts_pkg::wsts_node_wr_t          node_wr, rb_node_wr;
    wsts_pkg::wsts_rd_t               node_rd;
    logic [wsts_pkg::WEIGHT_BITS-1:0] leaf_rdata;
    logic [SB-1:0]                    node_rdata;
    logic                             rb_done;
    logic [SB-1:0]                    rb_total;

    // shared subtract / compare unit
    logic [SB-1:0] alu_a, alu_b;
    logic [SB:0]   alu_diff;
    logic          alu_le;
    logic [SB-1:0] alu_sat;

    logic [wsts_pkg::WEIGHT_BITS-1:0] leaf_eff;
    logic [LB-1:0]                    leaf_pos;

    // ---------------- APB register ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[wsts_pkg::CFG_ADDR_BITS-1] == wsts_pkg::CFG_IDX_NUM_ITEMS)
                    ? wsts_pkg::CFG_DATA_BITS'(num_items_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_items_reg <= '0;
        end
        else if (cfg_wr &&
                 paddr[wsts_pkg::CFG_ADDR_BITS-1] == wsts_pkg::CFG_IDX_NUM_ITEMS)
        begin
            num_items_reg <= pwdata[IB-1:0];
        end
    end

    // ---------------- handshakes ----------------
    assign in_ready  = (state_reg == wsts_pkg::ST_IDLE) && !clear_busy;
    assign in_acc    = in_valid && in_ready;
    assign out_load  = (state_reg == wsts_pkg::ST_DONE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ---------------- shared unit ----------------
    assign leaf_pos = node_reg[LB-1:0];
    assign leaf_eff = ({1'b0, leaf_pos} < num_items_reg) ? leaf_rdata : '0;

    always_comb
    begin
        case (state_reg)
            wsts_pkg::ST_DESC_CMP:
            begin
                alu_a = query_reg;
                alu_b = node_rdata;
            end
            wsts_pkg::ST_LEAF_W:
            begin
                alu_a = total_reg;
                alu_b = SB'(leaf_eff);
            end
            wsts_pkg::ST_UP_WR:
            begin
                alu_a = node_rdata;
                alu_b = SB'(w_reg);
            end
            default:
            begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_le   = alu_diff[SB] || (alu_diff[SB-1:0] == '0);
    assign alu_sat  = alu_le ? '0 : alu_diff[SB-1:0];

    // ---------------- memory port muxing ----------------
    assign rb_start = in_acc && (in_data.cmd == wsts_pkg::CMD_REBUILD);

    assign leaf_wr.en   = in_acc && (in_data.cmd == wsts_pkg::CMD_LOAD);
    assign leaf_wr.addr = in_data.item_index;
    assign leaf_wr.data = in_data.weight;

    always_comb
    begin
        if (state_reg == wsts_pkg::ST_REBUILD)
        begin
            leaf_rd = rb_leaf_rd;
            node_wr = rb_node_wr;
        end
        else
        begin
            leaf_rd.en   = (state_reg == wsts_pkg::ST_LEAF_RD);
            leaf_rd.addr = leaf_pos;
            node_wr.en   = (state_reg == wsts_pkg::ST_UP_WR);
            node_wr.addr = node_reg[IB-1:1];
            node_wr.data = alu_sat;
        end
    end

    always_comb
    begin
        if (state_reg == wsts_pkg::ST_DESC_RD)
        begin
            node_rd.en   = 1'b1;
            node_rd.addr = node_reg[LB-1:0];
        end
        else
        begin
            // parent of a left child on the way back up
            node_rd.en   = (state_reg == wsts_pkg::ST_UP_CHK) && !node_reg[0]
                           && (node_reg != IB'(1));
            node_rd.addr = node_reg[IB-1:1];
        end
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next  = state_reg;
        node_next   = node_reg;
        query_next  = query_reg;
        remove_next = remove_reg;
        w_next      = w_reg;
        total_next  = total_reg;
        picked_next = picked_reg;
        case (state_reg)
            wsts_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    picked_next = '0;
                    node_next   = IB'(1);
                    query_next  = in_data.query;
                    remove_next = (in_data.cmd == wsts_pkg::CMD_REMOVE);
                    case (in_data.cmd)
                        wsts_pkg::CMD_LOAD:    state_next = wsts_pkg::ST_DONE;
                        wsts_pkg::CMD_REBUILD: state_next = wsts_pkg::ST_REBUILD;
                        default:               state_next = wsts_pkg::ST_DESC_RD;
                    endcase
                end
            end
            wsts_pkg::ST_REBUILD:
            begin
                if (rb_done)
                begin
                    total_next = rb_total;
                    state_next = wsts_pkg::ST_DONE;
                end
            end
            wsts_pkg::ST_DESC_RD:
            begin
                state_next = wsts_pkg::ST_DESC_CMP;
            end
            wsts_pkg::ST_DESC_CMP:
            begin
                if (alu_le)
                begin
                    node_next = {node_reg[IB-2:0], 1'b0};
                end
                else
                begin
                    node_next  = {node_reg[IB-2:0], 1'b1};
                    query_next = alu_diff[SB-1:0];
                end
                if (node_reg[LB-1])
                begin
                    // next index is a leaf
                    picked_next = ({1'b0, node_next[LB-1:0]} < num_items_reg)
                                  ? {1'b0, node_next[LB-1:0]} : num_items_reg;
                    state_next  = remove_reg ? wsts_pkg::ST_LEAF_RD : wsts_pkg::ST_DONE;
                end
                else
                begin
                    state_next = wsts_pkg::ST_DESC_RD;
                end
            end
            wsts_pkg::ST_LEAF_RD:
            begin
                state_next = wsts_pkg::ST_LEAF_W;
            end
            wsts_pkg::ST_LEAF_W:
            begin
                w_next     = leaf_eff;
                total_next = alu_sat;
                state_next = wsts_pkg::ST_UP_CHK;
            end
            wsts_pkg::ST_UP_CHK:
            begin
                if (node_reg == IB'(1))
                begin
                    state_next = wsts_pkg::ST_DONE;
                end
                else if (!node_reg[0])
                begin
                    state_next = wsts_pkg::ST_UP_WR;
                end
                else
                begin
                    node_next = node_reg >> 1;
                end
            end
            wsts_pkg::ST_UP_WR:
            begin
                node_next  = node_reg >> 1;
                state_next = wsts_pkg::ST_UP_CHK;
            end
            wsts_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = wsts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsts_pkg::ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        query_reg  <= query_next;
        remove_reg <= remove_next;
        w_reg      <= w_next;
        picked_reg <= picked_next;
        if (out_load)
        begin
            out_data_reg.picked_index  <= picked_reg;
            out_data_reg.remaining_sum <= total_reg;
        end
    end

    // ---------------- submodules ----------------
    wsts_rebuild u_rebuild (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (rb_start),
        .num_items  (num_items_reg),
        .leaf_rdata (leaf_rdata),
        .leaf_rd    (rb_leaf_rd),
        .node_wr    (rb_node_wr),
        .done       (rb_done),
        .total      (rb_total)
    );

    wsts_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .leaf_wr    (leaf_wr),
        .leaf_rd    (leaf_rd),
        .leaf_rdata (leaf_rdata),
        .node_wr    (node_wr),
        .node_rd    (node_rd),
        .node_rdata (node_rdata),
        .clear_busy (clear_busy)
    );

endmodule

// ===== rtl/wsts_store.sv =====
// Leaf weight memory and node left-sum memory with the post-reset clearing sweep.
`timescale 1ns / 1ps

module wsts_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  wsts_pkg::wsts_leaf_wr_t            leaf_wr,
    input  wsts_pkg::wsts_rd_t                 leaf_rd,
    output logic [wsts_pkg::WEIGHT_BITS-1:0]   leaf_rdata,
    input  wsts_pkg::wsts_node_wr_t            node_wr,
    input  wsts_pkg::wsts_rd_t                 node_rd,
    output logic [wsts_pkg::SUM_BITS-1:0]      node_rdata,
    output logic                               clear_busy
);

    logic [wsts_pkg::WEIGHT_BITS-1:0] leaf_mem [wsts_pkg::LEAVES];
    logic [wsts_pkg::SUM_BITS-1:0]    node_mem [wsts_pkg::LEAVES];   // entry 0 unused

    logic [wsts_pkg::IDX_BITS-1:0]    clr_cnt_reg;
    logic [wsts_pkg::WEIGHT_BITS-1:0] leaf_rdata_reg;
    logic [wsts_pkg::SUM_BITS-1:0]    node_rdata_reg;

    assign clear_busy = !clr_cnt_reg[wsts_pkg::LEAF_BITS];
    assign leaf_rdata = leaf_rdata_reg;
    assign node_rdata = node_rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (clear_busy)
        begin
            clr_cnt_reg <= clr_cnt_reg + wsts_pkg::IDX_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy)
        begin
            leaf_mem[clr_cnt_reg[wsts_pkg::LEAF_BITS-1:0]] <= '0;
        end
        else if (leaf_wr.en)
        begin
            leaf_mem[leaf_wr.addr] <= leaf_wr.data;
        end
        if (leaf_rd.en)
        begin
            leaf_rdata_reg <= leaf_mem[leaf_rd.addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clear_busy)
        begin
            node_mem[clr_cnt_reg[wsts_pkg::LEAF_BITS-1:0]] <= '0;
        end
        else if (node_wr.en)
        begin
            node_mem[node_wr.addr] <= node_wr.data;
        end
        if (node_rd.en)
        begin
            node_rdata_reg <= node_mem[node_rd.addr];
        end
    end

endmodule

// ===== rtl/wsts_rebuild.sv =====
// Streaming rebuild: prefix-sums leaves in order, emits a left-subtree sum per leaf but the last.
`timescale 1ns / 1ps

module wsts_rebuild (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [wsts_pkg::IDX_BITS-1:0]      num_items,
    input  logic [wsts_pkg::WEIGHT_BITS-1:0]   leaf_rdata,
    output wsts_pkg::wsts_rd_t                 leaf_rd,
    output wsts_pkg::wsts_node_wr_t            node_wr,
    output logic                               done,
    output logic [wsts_pkg::SUM_BITS-1:0]      total
);

    localparam int LB = wsts_pkg::LEAF_BITS;

    logic [wsts_pkg::IDX_BITS-1:0]  rd_cnt_reg;
    logic                           s1_valid_reg;
    logic [LB-1:0]                  s1_idx_reg;
    logic                           s2_valid_reg;
    logic [wsts_pkg::IDX_BITS-1:0]  s2_cnt_reg;
    logic [wsts_pkg::SUM_BITS-1:0]  prefix_reg;
    logic [wsts_pkg::SUM_BITS-1:0]  base_reg [LB];   // prefix at start of a 2^(j+1) block

    logic                             issue;
    logic [wsts_pkg::WEIGHT_BITS-1:0] w_eff;
    logic [wsts_pkg::LVL_BITS-1:0]    lvl;
    logic [LB-1:0]                    wr_addr;
    logic [wsts_pkg::SUM_BITS-1:0]    base_sel;

    assign issue = !rd_cnt_reg[LB];
    assign leaf_rd.en   = issue;
    assign leaf_rd.addr = rd_cnt_reg[LB-1:0];

    assign w_eff = ({1'b0, s1_idx_reg} < num_items) ? leaf_rdata : '0;

    // lowest set bit of the leaf count picks the node whose left half just closed
    always_comb
    begin
        lvl      = wsts_pkg::LVL_BITS'(LB);
        wr_addr  = '0;
        base_sel = '0;
        for (int j = LB - 1; j >= 0; j--)
        begin
            if (s2_cnt_reg[j])
            begin
                lvl = wsts_pkg::LVL_BITS'(j);
            end
        end
        for (int j = 0; j < LB; j++)
        begin
            if (lvl == wsts_pkg::LVL_BITS'(j))
            begin
                wr_addr  = LB'(1 << (LB - 1 - j)) | LB'(s2_cnt_reg >> (j + 1));
                base_sel = base_reg[j];
            end
        end
    end

    assign node_wr.en   = s2_valid_reg && !s2_cnt_reg[LB];
    assign node_wr.addr = wr_addr;
    assign node_wr.data = prefix_reg - base_sel;

    assign done  = s2_valid_reg && s2_cnt_reg[LB];
    assign total = prefix_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg   <= wsts_pkg::IDX_BITS'(wsts_pkg::LEAVES);
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (start)
        begin
            rd_cnt_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + wsts_pkg::IDX_BITS'(1);
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prefix_reg <= '0;
            for (int j = 0; j < LB; j++)
            begin
                base_reg[j] <= '0;
            end
        end
        else
        begin
            s1_idx_reg <= rd_cnt_reg[LB-1:0];
            if (s1_valid_reg)
            begin
                prefix_reg <= prefix_reg + wsts_pkg::SUM_BITS'(w_eff);
                s2_cnt_reg <= {1'b0, s1_idx_reg} + wsts_pkg::IDX_BITS'(1);
            end
            if (s2_valid_reg)
            begin
                for (int j = 0; j < LB; j++)
                begin
                    if (wsts_pkg::LVL_BITS'(j) < lvl)
                    begin
                        base_reg[j] <= prefix_reg;
                    end
                end
            end
        end
    end

endmodule
